@@ rtl/sca_pkg.sv @@
package sca_pkg;

  localparam int FREE_DEPTH = 1024;
  localparam int AW = $clog2(FREE_DEPTH);
  localparam int CW = AW + 1;

  localparam logic [2:0] CFG_CHUNK_BYTES = 3'd0;
  localparam logic [2:0] CFG_PAGE_BYTES = 3'd1;
  localparam logic [2:0] CFG_CHUNKS_PER_PAGE = 3'd2;
  localparam logic [2:0] CFG_MAX_PAGES = 3'd3;
  localparam logic [2:0] CFG_REGION_BASE = 3'd4;

  localparam logic [2:0] ST_FROM_STACK = 3'd0;
  localparam logic [2:0] ST_FROM_PAGE = 3'd1;
  localparam logic [2:0] ST_NO_MEMORY = 3'd2;
  localparam logic [2:0] ST_FREED = 3'd3;
  localparam logic [2:0] ST_REJECTED = 3'd4;

  localparam logic [2:0] ACT_POP = 3'd0;
  localparam logic [2:0] ACT_PAGE = 3'd1;
  localparam logic [2:0] ACT_NOMEM = 3'd2;
  localparam logic [2:0] ACT_PUSH = 3'd3;
  localparam logic [2:0] ACT_REJECT = 3'd4;

  typedef struct packed {
    logic       load;
    logic       exec;
    logic [2:0] act;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic stack_empty;
    logic stack_full;
    logic page_open;
    logic page_avail;
    logic addr_zero;
  } stat_t;

endpackage

@@ rtl/sca_ctrl.sv @@
module sca_ctrl
  import sca_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy,
  output logic  done
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic [2:0] act;

  always_comb begin
    priority if (!stat.is_free) begin
      priority if (!stat.stack_empty) act = ACT_POP;
      else if (stat.page_open || stat.page_avail) act = ACT_PAGE;
      else act = ACT_NOMEM;
    end else begin
      if (stat.addr_zero || stat.stack_full) act = ACT_REJECT;
      else act = ACT_PUSH;
    end
  end

  assign busy = (state == S_EXEC);
  assign cmd.load = start && (state == S_IDLE);
  assign cmd.exec = (state == S_EXEC);
  assign cmd.act = act;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= (state == S_EXEC);
      unique case (state)
        S_IDLE: if (start) state <= S_EXEC;
        S_EXEC: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/sca_datapath.sv @@
module sca_datapath
  import sca_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic        mode,
  input  logic [31:0] free_addr,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic [31:0] chunk_addr,
  output logic [2:0]  status
);

  logic [20:0] chunk_bytes;
  logic [20:0] page_bytes;
  logic [15:0] chunks_per_page;
  logic [15:0] max_pages;

  logic [31:0] free_stack [FREE_DEPTH];
  logic [CW-1:0] free_count;
  logic page_open;
  logic [31:0] next_chunk_addr;
  logic [15:0] chunks_left;
  logic [15:0] pages_used;
  logic [31:0] next_page_base;

  logic req_mode;
  logic [31:0] req_addr;

  logic [31:0] rd_data;
  logic from_stack;
  logic [31:0] res_addr;
  logic [2:0] res_status;

  logic [31:0] cur_addr;
  logic [15:0] cur_left;
  logic [15:0] left_next;
  logic [31:0] chunk_step;
  logic [CW-1:0] count_dec;

  assign stat.is_free = req_mode;
  assign stat.stack_empty = (free_count == '0);
  assign stat.stack_full = (free_count == CW'(FREE_DEPTH));
  assign stat.page_open = page_open;
  assign stat.page_avail = (pages_used < max_pages);
  assign stat.addr_zero = (req_addr == 32'd0);

  always_comb begin
    count_dec = free_count - CW'(1);
    if (page_open) begin
      cur_addr = next_chunk_addr;
      cur_left = chunks_left;
    end else begin
      cur_addr = next_page_base;
      cur_left = (chunks_per_page == 16'd0) ? 16'd1 : chunks_per_page;
    end
    left_next = cur_left - 16'd1;
    chunk_step = cur_addr + {11'd0, chunk_bytes};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode <= mode;
      req_addr <= free_addr;
    end
    if (cmd.exec && cmd.act == ACT_POP) begin
      rd_data <= free_stack[count_dec[AW-1:0]];
    end
    if (cmd.exec && cmd.act == ACT_PUSH) begin
      free_stack[free_count[AW-1:0]] <= req_addr;
    end
    if (cmd.exec) begin
      from_stack <= (cmd.act == ACT_POP);
      res_addr <= (cmd.act == ACT_PAGE) ? cur_addr : 32'd0;
      unique case (cmd.act)
        ACT_POP: res_status <= ST_FROM_STACK;
        ACT_PAGE: res_status <= ST_FROM_PAGE;
        ACT_NOMEM: res_status <= ST_NO_MEMORY;
        ACT_PUSH: res_status <= ST_FREED;
        default: res_status <= ST_REJECTED;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_bytes <= 21'd64;
      page_bytes <= 21'd1048576;
      chunks_per_page <= 16'd16384;
      max_pages <= 16'd16;
      free_count <= '0;
      page_open <= 1'b0;
      next_chunk_addr <= 32'd0;
      chunks_left <= 16'd0;
      pages_used <= 16'd0;
      next_page_base <= 32'd4096;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CHUNK_BYTES: chunk_bytes <= cfg_data[20:0];
          CFG_PAGE_BYTES: page_bytes <= cfg_data[20:0];
          CFG_CHUNKS_PER_PAGE: chunks_per_page <= cfg_data[15:0];
          CFG_MAX_PAGES: max_pages <= cfg_data[15:0];
          CFG_REGION_BASE: begin
            if (pages_used == 16'd0) next_page_base <= cfg_data;
          end
          default: ;
        endcase
      end
      if (cmd.exec) begin
        unique case (cmd.act)
          ACT_POP: free_count <= count_dec;
          ACT_PUSH: free_count <= free_count + CW'(1);
          ACT_PAGE: begin
            if (!page_open) begin
              pages_used <= pages_used + 16'd1;
              next_page_base <= next_page_base + {11'd0, page_bytes};
            end
            chunks_left <= left_next;
            if (left_next == 16'd0) begin
              page_open <= 1'b0;
              next_chunk_addr <= 32'd0;
            end else begin
              page_open <= 1'b1;
              next_chunk_addr <= chunk_step;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign chunk_addr = from_stack ? rd_data : res_addr;
  assign status = res_status;

endmodule

@@ rtl/slab_chunk_allocator.sv @@
// Every request is accepted in the idle state, then passes through the execute
// state, which updates the allocator state and does any stack memory access.
// The result word appears with done in the cycle after the execute cycle,
// while the next request can already be accepted; none is accepted while busy.
// Synchronous active-high reset restores the register defaults and empties
// the free stack; the stack memory itself is not cleared.
module slab_chunk_allocator
  import sca_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [31:0] free_addr,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [31:0] chunk_addr,
  output logic [2:0]  status
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  sca_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  sca_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .mode       (mode),
    .free_addr  (free_addr),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .chunk_addr (chunk_addr),
    .status     (status)
  );

endmodule

@@ verif/slab_chunk_allocator_tb.sv @@
`timescale 1ns / 100ps

module slab_chunk_allocator_tb;
  import sca_pkg::*;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE = 1'b1;
  localparam logic [2:0] CFG_BEYOND = 3'd7;
  localparam int CYCLE_LIMIT = 300000;
  localparam int NUM_PHASES = 12;
  localparam int FILL_PHASE = 6;
  localparam int DIR_ROWS = 37;

  typedef struct packed {
    logic        is_cfg;
    logic [2:0]  idx;
    logic        mode;
    logic [31:0] val;
    logic        typed;
    logic [31:0] exp_addr;
    logic [2:0]  exp_status;
  } dir_row_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [2:0]  status;
  } alloc_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        mode = 1'b0;
  logic [31:0] free_addr = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CFG_CHUNK_BYTES;
  logic [31:0] cfg_data = '0;
  logic        done;
  logic [31:0] chunk_addr;
  logic [2:0]  status;

  logic [20:0] reg_chunk_bytes = 21'd64;
  logic [20:0] reg_page_bytes = 21'd1048576;
  logic [15:0] reg_chunks_per_page = 16'd16384;
  logic [15:0] reg_max_pages = 16'd16;

  logic [31:0] stk_mem [FREE_DEPTH];
  int          stk_count = 0;
  logic        pg_open = 1'b0;
  logic [31:0] pg_next_addr = '0;
  logic [15:0] pg_left = '0;
  logic [15:0] pg_used = '0;
  logic [31:0] pg_next_base = 32'd4096;

  alloc_result_t pending_results [$];
  logic [31:0]   live_addrs [$];
  alloc_result_t want;
  int            err_count = 0;
  int            cycle_count = 0;
  bit            idle_on = 1'b1;

  dir_row_t dir_table [DIR_ROWS] = '{
    '{1'b1, CFG_REGION_BASE, MODE_ALLOC, 32'h0, 1'b0, 32'h0, ST_FROM_STACK},
    '{1'b1, CFG_REGION_BASE, MODE_ALLOC, 32'hFFF00000, 1'b0, 32'h0, ST_FROM_STACK},
    '{1'b1, CFG_CHUNK_BYTES, MODE_ALLOC, 32'h00100000, 1'b0, 32'h0, ST_FROM_STACK},
    '{1'b1, CFG_CHUNKS_PER_PAGE, MODE_ALLOC, 32'd2, 1'b0, 32'h0, ST_FROM_STACK},
    '{1'b1, CFG_MAX_PAGES, MODE_ALLOC, 32'd3, 1'b0, 32'h0, ST_FROM_STACK},
    '{1'b0, CFG_BEYOND, MODE_ALLOC, 32'h0, 1'b1, 32'hFFF00000, ST_FROM_PAGE},
    '{1'b0, CFG_BEYOND, MODE_ALLOC, 32'h0, 1'b1, 32'h0, ST_FROM_PAGE},
    '{1'b0, CFG_BEYOND, MODE_FREE, 32'h0, 1'b1, 32'h0, ST_REJECTED},
    '{1'b0, CFG_BEYOND, MODE_ALLOC, 32'h0, 1'b1, 32'h0, ST_FROM_PAGE},
    '{1'b0, CFG_BEYOND, MODE_FREE, 32'hFFFFFFFF, 1'b1, 32'h0, ST_FREED},
    '{1'b0, CFG_BEYOND, MODE_ALLOC, 32'h0, 1'b1, 32'hFFFFFFFF, ST_FROM_STACK},
    '{1'b0, CFG_BEYOND, MODE_ALLOC, 32'h0, 1'b1, 32'h00100000, ST_FROM_PAGE},
    '{1'b1, CFG_CHUNKS_PER_PAGE, MODE_ALLOC, 32'd0, 1'b0, 32'h0, ST_FROM_STACK},
    '{1'b0, CFG_BEYOND, MODE_ALLOC, 32'h0, 1'b1, 32'h00100000, ST_FROM_PAGE},
    '{1'b0, CFG_BEYOND, MODE_ALLOC, 32'h0, 1'b1, 32'h0, ST_NO_MEMORY},
    '{1'b1, CFG_MAX_PAGES, MODE_ALLOC, 32'd0, 1'b0, 32'h0, ST_FROM_STACK},
    '{1'b0, CFG_BEYOND, MODE_FREE, 32'h1, 1'b1, 32'h0, ST_FREED},
    '{1'b0, CFG_BEYOND, MODE_FREE, 32'h1, 1'b1, 32'h0, ST_FREED},
    '{1'b0, CFG_BEYOND, MODE_ALLOC, 32'h0, 1'b1, 32'h1, ST_FROM_STACK},
    '{1'b0, CFG_BEYOND, MODE_ALLOC, 32'h0, 1'b1, 32'h1, ST_FROM_STACK},
    '{1'b0, CFG_BEYOND, MODE_ALLOC, 32'h0, 1'b1, 32'h0, ST_NO_MEMORY},
    '{1'b1, CFG_MAX_PAGES, MODE_ALLOC, 32'd65535, 1'b0, 32'h0, ST_FROM_STACK},
    '{1'b1, CFG_CHUNKS_PER_PAGE, MODE_ALLOC, 32'd3, 1'b0, 32'h0, ST_FROM_STACK},
    '{1'b1, CFG_CHUNK_BYTES, MODE_ALLOC, 32'd0, 1'b0, 32'h0, ST_FROM_STACK},
    '{1'b1, CFG_PAGE_BYTES, MODE_ALLOC, 32'd1, 1'b0, 32'h0, ST_FROM_STACK},
    '{1'b1, CFG_REGION_BASE, MODE_ALLOC, 32'h1000, 1'b0, 32'h0, ST_FROM_STACK},
    '{1'b0, CFG_BEYOND, MODE_ALLOC, 32'hFFFFFFFF, 1'b1, 32'h00200000, ST_FROM_PAGE},
    '{1'b0, CFG_BEYOND, MODE_ALLOC, 32'h0, 1'b1, 32'h00200000, ST_FROM_PAGE},
    '{1'b1, CFG_BEYOND, MODE_ALLOC, 32'hFFFFFFFF, 1'b0, 32'h0, ST_FROM_STACK},
    '{1'b1, CFG_CHUNK_BYTES, MODE_ALLOC, 32'd64, 1'b0, 32'h0, ST_FROM_STACK},
    '{1'b1, CFG_PAGE_BYTES, MODE_ALLOC, 32'h00100000, 1'b0, 32'h0, ST_FROM_STACK},
    '{1'b0, CFG_BEYOND, MODE_ALLOC, 32'h0, 1'b1, 32'h00200000, ST_FROM_PAGE},
    '{1'b0, CFG_BEYOND, MODE_ALLOC, 32'h0, 1'b0, 32'h0, ST_FROM_STACK},
    '{1'b0, CFG_BEYOND, MODE_FREE, 32'hA5A5A5A5, 1'b0, 32'h0, ST_FROM_STACK},
    '{1'b0, CFG_BEYOND, MODE_ALLOC, 32'h0, 1'b0, 32'h0, ST_FROM_STACK},
    '{1'b0, CFG_BEYOND, MODE_ALLOC, 32'h0, 1'b0, 32'h0, ST_FROM_STACK},
    '{1'b0, CFG_BEYOND, MODE_FREE, 32'h5A5A5A5A, 1'b0, 32'h0, ST_FROM_STACK}
  };

  slab_chunk_allocator i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .free_addr(free_addr),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .chunk_addr(chunk_addr),
    .status(status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual addr %h status %0d",
                 $time, chunk_addr, status);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (chunk_addr !== want.addr) begin
          $display("%0t: chunk_addr mismatch, expected %h, actual %h",
                   $time, want.addr, chunk_addr);
          err_count++;
        end
        if (status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, status);
          err_count++;
        end
      end
    end
  end

  task automatic apply_reg_write(input logic [2:0] idx, input logic [31:0] data);
    case (idx)
      CFG_CHUNK_BYTES: reg_chunk_bytes = data[20:0];
      CFG_PAGE_BYTES: reg_page_bytes = data[20:0];
      CFG_CHUNKS_PER_PAGE: reg_chunks_per_page = data[15:0];
      CFG_MAX_PAGES: reg_max_pages = data[15:0];
      CFG_REGION_BASE: begin
        if (pg_used == 0) pg_next_base = data;
      end
      default: ;
    endcase
  endtask

  task automatic predict_request(input logic m, input logic [31:0] a,
                                 output alloc_result_t r);
    r.addr = '0;
    if (m == MODE_ALLOC) begin
      if (stk_count > 0) begin
        stk_count--;
        r.addr = stk_mem[stk_count];
        r.status = ST_FROM_STACK;
      end else begin
        if (!pg_open && pg_used < reg_max_pages) begin
          pg_open = 1'b1;
          pg_next_addr = pg_next_base;
          pg_left = (reg_chunks_per_page == 0) ? 16'd1 : reg_chunks_per_page;
          pg_used++;
          pg_next_base = pg_next_base + reg_page_bytes;
        end
        if (pg_open) begin
          r.addr = pg_next_addr;
          r.status = ST_FROM_PAGE;
          pg_left--;
          if (pg_left == 0) begin
            pg_open = 1'b0;
            pg_next_addr = '0;
          end else begin
            pg_next_addr = pg_next_addr + reg_chunk_bytes;
          end
        end else begin
          r.status = ST_NO_MEMORY;
        end
      end
      if (r.status != ST_NO_MEMORY) live_addrs.push_back(r.addr);
    end else if (a == 0 || stk_count >= FREE_DEPTH) begin
      r.status = ST_REJECTED;
    end else begin
      stk_mem[stk_count] = a;
      stk_count++;
      r.status = ST_FREED;
    end
  endtask

  // Returns in the time step of acceptance with start still high.
  task automatic issue_request(input logic m, input logic [31:0] a, input logic typed,
                               input alloc_result_t typed_res);
    int gap;
    alloc_result_t r;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      mode <= 1'($urandom_range(0, 1));
      free_addr <= $urandom;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    mode <= m;
    free_addr <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_request(m, a, r);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg_write(idx, data);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_free_addr();
    int sel;
    int idx;
    sel = $urandom_range(0, 9);
    if (sel < 6 && live_addrs.size() > 0) begin
      idx = $urandom_range(0, live_addrs.size() - 1);
      pick_free_addr = live_addrs[idx];
      live_addrs.delete(idx);
    end else if (sel == 6) begin
      pick_free_addr = '0;
    end else if (sel == 7) begin
      pick_free_addr = '1;
    end else begin
      pick_free_addr = $urandom;
    end
  endfunction

  initial begin
    dir_row_t      row;
    alloc_result_t typed_res;
    bit            cfg_active;
    int            n_items;
    int            alloc_pct;
    logic [31:0]   v;
    bit            last_phase;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    cfg_active = 1'b0;
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_table[i];
      if (row.is_cfg) begin
        if (!cfg_active) wait_idle();
        write_reg(row.idx, row.val);
        cfg_active = 1'b1;
      end else begin
        if (cfg_active) cfg_valid <= 1'b0;
        cfg_active = 1'b0;
        typed_res.addr = row.exp_addr;
        typed_res.status = row.exp_status;
        issue_request(row.mode, row.val, row.typed, typed_res);
      end
    end

    typed_res = '0;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      last_phase = (phase == NUM_PHASES - 1);
      wait_idle();
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 4))
          0: v = 32'd0;
          1: v = 32'd1;
          2: v = 32'h00100000;
          default: v = $urandom_range(1, 4096);
        endcase
        write_reg(CFG_CHUNK_BYTES, v);
      end
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 3))
          0: v = 32'd1;
          1: v = 32'h00100000;
          default: v = $urandom_range(1, 32'h00100000);
        endcase
        write_reg(CFG_PAGE_BYTES, v);
      end
      if (last_phase || $urandom_range(0, 1)) begin
        // A page opened at the largest size never drains, so it comes last.
        if (last_phase) v = 32'd65535;
        else if ($urandom_range(0, 3) == 0) v = 32'd0;
        else v = $urandom_range(1, 6);
        write_reg(CFG_CHUNKS_PER_PAGE, v);
      end
      if (last_phase || $urandom_range(0, 1)) begin
        case ($urandom_range(0, 4))
          0: v = 32'd0;
          1: v = 32'd65535;
          default: v = pg_used + $urandom_range(0, 4);
        endcase
        if (last_phase || v > 65535) v = 32'd65535;
        write_reg(CFG_MAX_PAGES, v);
      end
      if ($urandom_range(0, 1)) write_reg(CFG_REGION_BASE, $urandom);
      if ($urandom_range(0, 3) == 0) begin
        write_reg(3'($urandom_range(CFG_REGION_BASE + 1, CFG_BEYOND)), $urandom);
      end
      cfg_valid <= 1'b0;
      idle_on = ($urandom_range(0, 3) != 0);

      if (phase == FILL_PHASE) begin
        while (stk_count < FREE_DEPTH) issue_request(MODE_FREE, $urandom, 1'b0, typed_res);
        repeat (3) issue_request(MODE_FREE, $urandom, 1'b0, typed_res);
      end

      n_items = $urandom_range(35, 65);
      alloc_pct = 25 * $urandom_range(1, 3);
      repeat (n_items) begin
        if ($urandom_range(1, 100) <= alloc_pct) begin
          issue_request(MODE_ALLOC, $urandom, 1'b0, typed_res);
        end else begin
          issue_request(MODE_FREE, pick_free_addr(), 1'b0, typed_res);
        end
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/sca_pkg.sv
rtl/sca_ctrl.sv
rtl/sca_datapath.sv
rtl/slab_chunk_allocator.sv
verif/slab_chunk_allocator_tb.sv
